>>> hw/rtl/vssp_pkg.sv
`timescale 1ns / 1ps

package vssp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_ERROR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CEIL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CW_LEVEL    = 3'd7;

  // field widths
  localparam int DZ_W    = 12;
  localparam int RATIO_W = 16;
  localparam int LIMIT_W = 15;
  localparam int FULL_W  = 12;
  localparam int SPEED_W = 20;
  localparam int CLK_W   = 30;
  localparam int ERR_W   = 13;
  localparam int STEPS_W = 16;
  localparam int CMP_W   = 29;
  localparam int RLD_W   = 30;

  // register reset values
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST  = 12'd5;
  localparam logic [RATIO_W-1:0] STEP_RATIO_RST = 16'd256;
  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 15'd1000;
  localparam logic [FULL_W-1:0]  FULL_ERROR_RST = 12'd320;
  localparam logic [SPEED_W-1:0] RATE_FLOOR_RST = 20'd1000;
  localparam logic [SPEED_W-1:0] RATE_CEIL_RST  = 20'd500000;
  localparam logic [CLK_W-1:0]   CLOCK_HZ_RST   = 30'd550000000;
  localparam logic               CW_LEVEL_RST   = 1'b1;

  localparam int RATIO_FRAC_BITS_DEF = 8;

  // serial multiplier: multiplicand x multiplier, one multiplier bit a cycle
  localparam int MUL_A_W = SPEED_W;
  localparam int MUL_B_W = RATIO_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // restoring divider: one quotient bit a cycle
  localparam int DIV_NUM_W = SPEED_W + ERR_W;
  localparam int DIV_DEN_W = SPEED_W;

endpackage

>>> hw/rtl/vssp_mul.sv
`timescale 1ns / 1ps

module vssp_mul import vssp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_P_W-1:0] p_r;
  logic [MUL_A_W:0]   sum;

  // upper half accumulates, multiplier bits leave at the bottom
  assign sum  = {1'b0, p_r[MUL_P_W-1:MUL_B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign prod = p_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(MUL_B_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{MUL_A_W{1'b0}}, b};
    end else if (busy) begin
      p_r <= {sum, p_r[MUL_B_W-1:1]};
    end
  end

endmodule

>>> hw/rtl/vssp_div.sv
`timescale 1ns / 1ps

module vssp_div import vssp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DIV_NUM_W-1:0] sh;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W+1:0] trial;
  logic [DIV_DEN_W-1:0] rem_next;

  // numerator bits leave at the top, quotient bits enter at the bottom
  assign trial    = {1'b0, rem, sh[DIV_NUM_W-1]} - {2'b00, den_r};
  assign rem_next = trial[DIV_DEN_W+1] ? {rem[DIV_DEN_W-2:0], sh[DIV_NUM_W-1]}
                                       : trial[DIV_DEN_W-1:0];
  assign quot     = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      sh  <= {sh[DIV_NUM_W-2:0], ~trial[DIV_DEN_W+1]};
      rem <= rem_next;
    end
  end

endmodule

>>> hw/rtl/vision_servo_stepper_pulser.sv
`timescale 1ns / 1ps

// Step/direction pulser driven by vision pixel error.
// Input channel (in_valid/in_ready): func = 0 carries a pixel error command,
// func = 1 is one timer tick. Output channel (out_valid/out_ready): one
// result item per input item, in order.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per cycle; the user must write it only while no item is in flight, as the
// block itself does not enforce this. One item is worked on at a time;
// in_ready is high only when idle, which returns in the same cycle that
// out_valid rises. A dead-zone command, or a tick with nothing pending, goes
// straight to the output stage; a tick with steps pending runs one division;
// a command runs both multipliers and then two divisions. The work is
// done by the shared bit-serial divider (one quotient bit per cycle, used
// twice per command) and the bit-serial multipliers.
// The result sits in an output register; the next item can be accepted while
// it waits. A finished item waits for that register to drain before it is
// written, so a stalled receiver eventually holds off in_ready.
// Reset (rst, synchronous) restores the register defaults, clears the
// pending step count, step rate and motion flag, and empties the output.

module vision_servo_stepper_pulser import vssp_pkg::*; #(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic signed [ERR_W-1:0] pixel_error,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    dir_level,
  output logic [CMP_W-1:0]        compare_value,
  output logic                    compare_write,
  output logic [RLD_W-1:0]        reload_value,
  output logic                    reload_write,
  output logic                    moving,
  output logic signed [STEPS_W-1:0] steps_left
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_DIV_RATE = 3'd2;
  localparam logic [2:0] S_DIV_CLK  = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  localparam logic signed [STEPS_W-1:0] ONE_STEP = STEPS_W'(1);

  // configuration registers
  logic [DZ_W-1:0]    dead_zone;
  logic [RATIO_W-1:0] step_ratio_q8;
  logic [LIMIT_W-1:0] step_limit;
  logic [FULL_W-1:0]  full_speed_error;
  logic [SPEED_W-1:0] rate_floor;
  logic [SPEED_W-1:0] rate_ceil;
  logic [CLK_W-1:0]   clock_hz;
  logic               cw_level;

  // block state
  logic [2:0]                state;
  logic signed [STEPS_W-1:0] pending;
  logic [SPEED_W-1:0]        step_rate;
  logic                      moving_flag;
  logic                      func_r;
  logic                      neg_r;

  // result staging
  logic             res_dir;
  logic [CMP_W-1:0] res_cmp;
  logic             res_cmp_wr;
  logic [RLD_W-1:0] res_rld;
  logic             res_rld_wr;

  logic              in_accept;
  logic              out_load;
  logic [ERR_W-1:0]  mag_in;
  logic              dead_in;
  logic [FULL_W-1:0] full_eff;
  logic [FULL_W-1:0] part_in;

  logic               mul_start;
  logic               mul1_done;
  logic               mul2_done;
  logic [MUL_P_W-1:0] mul1_prod;
  logic [MUL_P_W-1:0] mul2_prod;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  logic [MUL_P_W-1:0] scaled_full;
  logic [LIMIT_W-1:0] sat;
  logic [STEPS_W-1:0] sat_ext;
  logic [SPEED_W-1:0] tick_den;
  logic [SPEED_W-1:0] rate_raw;
  logic [SPEED_W-1:0] rate_clamp;
  logic [SPEED_W-1:0] rate_final;
  logic [CLK_W-1:0]   q_clk;
  logic signed [STEPS_W-1:0] pending_next;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // magnitude of the error; -4096 maps to 4096, which still fits
  assign mag_in   = pixel_error[ERR_W-1] ? (~pixel_error + 1'b1) : pixel_error;
  assign dead_in  = (mag_in < {1'b0, dead_zone});
  assign full_eff = (full_speed_error == '0) ? FULL_W'(1) : full_speed_error;
  assign part_in  = (mag_in < {1'b0, full_eff}) ? mag_in[FULL_W-1:0] : full_eff;

  assign mul_start = in_accept && !func && !dead_in;

  vssp_mul u_mul_steps (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (MUL_A_W'(mag_in)),
    .b    (step_ratio_q8),
    .done (mul1_done),
    .prod (mul1_prod)
  );

  vssp_mul u_mul_speed (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (rate_ceil),
    .b    (MUL_B_W'(part_in)),
    .done (mul2_done),
    .prod (mul2_prod)
  );

  // step count: truncate the fraction, saturate at the limit
  assign scaled_full = mul1_prod >> RATIO_FRAC_BITS;
  assign sat     = (scaled_full > MUL_P_W'(step_limit)) ? step_limit
                                                        : scaled_full[LIMIT_W-1:0];
  assign sat_ext = {1'b0, sat};

  // rate from the first division; the floor wins over the ceiling
  assign rate_raw = div_quot[SPEED_W-1:0];
  always_comb begin
    if (rate_raw < rate_floor) begin
      rate_clamp = rate_floor;
    end else if (rate_raw > rate_ceil) begin
      rate_clamp = rate_ceil;
    end else begin
      rate_clamp = rate_raw;
    end
  end
  assign rate_final = (rate_clamp == '0) ? SPEED_W'(1) : rate_clamp;
  assign tick_den   = (step_rate == '0) ? SPEED_W'(1) : step_rate;

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(clock_hz);
    div_den   = tick_den;
    unique case (state)
      S_IDLE: begin
        div_start = in_accept && func && (pending != '0);
      end
      S_MUL: begin
        div_start = mul1_done && mul2_done;
        div_num   = mul2_prod[DIV_NUM_W-1:0];
        div_den   = DIV_DEN_W'(full_eff);
      end
      S_DIV_RATE: begin
        div_start = div_done;
        div_den   = rate_final;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  vssp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign q_clk        = div_quot[CLK_W-1:0];
  assign pending_next = pending[STEPS_W-1] ? (pending + ONE_STEP) : (pending - ONE_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      pending          <= '0;
      step_rate        <= '0;
      moving_flag      <= 1'b0;
      dead_zone        <= DEAD_ZONE_RST;
      step_ratio_q8    <= STEP_RATIO_RST;
      step_limit       <= STEP_LIMIT_RST;
      full_speed_error <= FULL_ERROR_RST;
      rate_floor       <= RATE_FLOOR_RST;
      rate_ceil        <= RATE_CEIL_RST;
      clock_hz         <= CLOCK_HZ_RST;
      cw_level         <= CW_LEVEL_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEAD_ZONE:  dead_zone        <= cfg_data[DZ_W-1:0];
          REG_STEP_RATIO: step_ratio_q8    <= cfg_data[RATIO_W-1:0];
          REG_STEP_LIMIT: step_limit       <= cfg_data[LIMIT_W-1:0];
          REG_FULL_ERROR: full_speed_error <= cfg_data[FULL_W-1:0];
          REG_RATE_FLOOR: rate_floor       <= cfg_data[SPEED_W-1:0];
          REG_RATE_CEIL:  rate_ceil        <= cfg_data[SPEED_W-1:0];
          REG_CLOCK_HZ:   clock_hz         <= cfg_data[CLK_W-1:0];
          REG_CW_LEVEL:   cw_level         <= cfg_data[0];
          default:        cw_level         <= cw_level;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            func_r     <= func;
            neg_r      <= pixel_error[ERR_W-1];
            res_dir    <= 1'b0;
            res_cmp    <= '0;
            res_cmp_wr <= func;
            res_rld    <= '0;
            res_rld_wr <= 1'b0;
            if (!func) begin
              if (dead_in) begin
                pending <= '0;
                state   <= S_DONE;
              end else begin
                state <= S_MUL;
              end
            end else if (pending == '0) begin
              moving_flag <= 1'b0;
              state       <= S_DONE;
            end else begin
              state <= S_DIV_CLK;
            end
          end
        end
        S_MUL: begin
          if (mul1_done && mul2_done) begin
            pending <= neg_r ? (~sat_ext + 1'b1) : sat_ext;
            state   <= S_DIV_RATE;
          end
        end
        S_DIV_RATE: begin
          if (div_done) begin
            step_rate <= rate_final;
            state     <= S_DIV_CLK;
          end
        end
        S_DIV_CLK: begin
          if (div_done) begin
            if (!func_r) begin
              // period saturates at zero when the clock is below the rate
              res_rld     <= (q_clk == '0) ? '0 : (q_clk - 1'b1);
              res_rld_wr  <= 1'b1;
              moving_flag <= 1'b1;
            end else begin
              res_dir     <= pending[STEPS_W-1] ? ~cw_level : cw_level;
              res_cmp     <= q_clk[CLK_W-1:1];
              pending     <= pending_next;
              moving_flag <= (pending_next != '0);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            dir_level     <= res_dir;
            compare_value <= res_cmp;
            compare_write <= res_cmp_wr;
            reload_value  <= res_rld;
            reload_write  <= res_rld_wr;
            moving        <= moving_flag;
            steps_left    <= pending;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(compare_write && reload_write))
    else $error("compare and reload written by one item");

  a_steps_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && (steps_left != '0) |-> moving)
    else $error("steps pending without motion flag");

  a_idle_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !compare_write |-> (compare_value == '0) && !dir_level)
    else $error("compare or direction driven on a command");

endmodule
